### src/mpq_pkg.sv
// package for the min priority queue: sizes, codes and shared types
package mpq_pkg;

    localparam int DEPTH        = 16;
    localparam int PAYLOAD_BITS = 16;
    localparam int KEY_BITS     = 32;
    localparam int TAG_BITS     = 16;
    localparam int STORE_BITS   = (PAYLOAD_BITS < TAG_BITS) ? PAYLOAD_BITS : TAG_BITS;
    localparam int CNT_W        = $clog2(DEPTH + 1);

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_POP_EMPTY  = 2'd1,
        ST_PUSH_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic                  push;
        logic                  pop;
        logic [KEY_BITS-1:0]   key;
        logic [STORE_BITS-1:0] tag;
    } t_ctl;

    typedef struct packed {
        logic [KEY_BITS-1:0]   pri;
        logic [STORE_BITS-1:0] pay;
        logic                  le;
    } t_link;

    typedef struct packed {
        logic [KEY_BITS-1:0] out_priority;
        logic [TAG_BITS-1:0] out_payload;
        logic                out_valid;
        logic                is_empty;
        logic                is_full;
        logic [1:0]          status;
    } t_result;

endpackage

### src/mpq_if.sv
// handshake interfaces for the command and result words
interface mpq_in_if import mpq_pkg::*;;
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [KEY_BITS-1:0] key_priority;
    logic [TAG_BITS-1:0] tag_payload;

    modport source (output valid, cmd, key_priority, tag_payload, input ready);
    modport sink   (input valid, cmd, key_priority, tag_payload, output ready);
endinterface

interface mpq_out_if import mpq_pkg::*;;
    logic                valid;
    logic                ready;
    logic [KEY_BITS-1:0] out_priority;
    logic [TAG_BITS-1:0] out_payload;
    logic                out_valid;
    logic                is_empty;
    logic                is_full;
    logic [1:0]          status;

    modport source (output valid, out_priority, out_payload, out_valid, is_empty, is_full,
                    status, input ready);
    modport sink   (input valid, out_priority, out_payload, out_valid, is_empty, is_full,
                    status, output ready);
endinterface

### src/min_priority_queue_top.sv
// min priority queue top level: sorted chain of slots, entry counter, result buffer
// a result word is registered in the output register, or in the skid stage on a stall
// throughput: one push or pop per cycle while input ready is high; each slot compares
// against the key in parallel and shifts to its neighbour, so every operation completes
// in the cycle it is taken; input ready drops only while the skid stage holds a word
// reset empties the queue (entry count to zero); slot contents are left as they are
module min_priority_queue_top import mpq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mpq_in_if.sink    i_in,
    mpq_out_if.source o_out
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_acc;
    logic             w_is_push;
    logic             w_full;
    logic             w_empty;
    logic             w_push_ok;
    logic             w_pop_ok;
    logic             w_buf_ready;
    t_ctl             w_ctl;
    t_result          w_res;
    t_link            w_link [DEPTH];
    logic             w_occ  [DEPTH];

    assign w_acc     = i_in.valid && i_in.ready;
    assign w_is_push = (i_in.cmd == CMD_PUSH);
    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_push_ok = w_acc && w_is_push && !w_full;
    assign w_pop_ok  = w_acc && !w_is_push && !w_empty;

    assign w_ctl.push = w_push_ok;
    assign w_ctl.pop  = w_pop_ok;
    assign w_ctl.key  = i_in.key_priority;
    assign w_ctl.tag  = STORE_BITS'(i_in.tag_payload);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_link w_prev;
            t_link w_next;

            assign w_occ[g] = (CNT_W'(g) < r_count);

            if (g == 0) begin : g_first
                assign w_prev = '{pri: '0, pay: '0, le: 1'b1};
            end else begin : g_mid
                assign w_prev = w_link[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign w_next = w_link[g];
            end else begin : g_rest
                assign w_next = w_link[g+1];
            end

            mpq_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl),
                .i_occ  (w_occ[g]),
                .i_prev (w_prev),
                .i_next (w_next),
                .o_link (w_link[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (w_push_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_comb begin
        w_res.out_priority = '0;
        w_res.out_payload  = '0;
        w_res.out_valid    = w_pop_ok;
        w_res.is_empty     = (n_count == '0);
        w_res.is_full      = (n_count == CNT_W'(DEPTH));
        w_res.status       = ST_OK;
        if (w_pop_ok) begin
            w_res.out_priority = w_link[0].pri;
            w_res.out_payload  = TAG_BITS'(w_link[0].pay);
        end
        if (w_is_push && w_full) begin
            w_res.status = ST_PUSH_FULL;
        end else if (!w_is_push && w_empty) begin
            w_res.status = ST_POP_EMPTY;
        end
    end

    assign i_in.ready = w_buf_ready;

    mpq_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_acc),
        .i_data  (w_res),
        .o_ready (w_buf_ready),
        .o_out   (o_out)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_ok |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push did not add an entry");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop_ok |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop did not remove an entry");

    a_head_is_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count > CNT_W'(1)) |-> (w_link[0].pri <= w_link[1].pri))
        else $error("head slot not the smallest");

endmodule

### src/mpq_cell.sv
// one slot of the sorted shift chain
module mpq_cell import mpq_pkg::*; (
    input  logic  i_clk,
    input  t_ctl  i_ctl,
    input  logic  i_occ,
    input  t_link i_prev,
    input  t_link i_next,
    output t_link o_link
);

    logic [KEY_BITS-1:0]   r_pri;
    logic [STORE_BITS-1:0] r_pay;
    logic [KEY_BITS-1:0]   n_pri;
    logic [STORE_BITS-1:0] n_pay;
    logic                  w_le;

    assign w_le = i_occ && (r_pri <= i_ctl.key);

    always_comb begin
        n_pri = r_pri;
        n_pay = r_pay;
        if (i_ctl.push) begin
            if (!w_le) begin
                if (i_prev.le) begin
                    n_pri = i_ctl.key;
                    n_pay = i_ctl.tag;
                end else begin
                    n_pri = i_prev.pri;
                    n_pay = i_prev.pay;
                end
            end
        end else if (i_ctl.pop) begin
            n_pri = i_next.pri;
            n_pay = i_next.pay;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pri <= n_pri;
        r_pay <= n_pay;
    end

    assign o_link.pri = r_pri;
    assign o_link.pay = r_pay;
    assign o_link.le  = w_le;

endmodule

### src/mpq_out_buf.sv
// result register with a skid stage
module mpq_out_buf import mpq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_result   i_data,
    output logic      o_ready,
    mpq_out_if.source o_out
);

    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out;
    t_result r_skid;
    logic    n_out_vld;
    logic    n_skid_vld;
    t_result n_out;
    t_result n_skid;
    logic    w_take;

    assign w_take  = o_out.valid && o_out.ready;
    assign o_ready = !r_skid_vld;

    always_comb begin
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        n_out      = r_out;
        n_skid     = r_skid;
        if (!r_out_vld || w_take) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_out_vld  = 1'b1;
                n_skid_vld = 1'b0;
            end else begin
                n_out     = i_data;
                n_out_vld = i_push;
            end
        end else if (i_push) begin
            n_skid     = i_data;
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.out_priority = r_out.out_priority;
    assign o_out.out_payload  = r_out.out_payload;
    assign o_out.out_valid    = r_out.out_valid;
    assign o_out.is_empty     = r_out.is_empty;
    assign o_out.is_full      = r_out.is_full;
    assign o_out.status       = r_out.status;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word held with no word in the output register");

    a_no_push_when_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> !i_push)
        else $error("word pushed while skid stage full");

    a_stall_holds_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> (r_out_vld && r_out == $past(r_out)))
        else $error("stalled result word changed");

endmodule
